// File: sv/prc_pkg.sv
// shared types and constants for the polygon rectangle clipper
// used by prc_ctrl, prc_datapath and polygon_rect_clipper_core
package prc_pkg;

   localparam int WIN_WIDTH = 16;

   localparam logic [1:0] REG_LEFT   = 2'd0;
   localparam logic [1:0] REG_TOP    = 2'd1;
   localparam logic [1:0] REG_RIGHT  = 2'd2;
   localparam logic [1:0] REG_BOTTOM = 2'd3;

   localparam logic signed [WIN_WIDTH-1:0] LEFT_RESET   = 16'sd0;
   localparam logic signed [WIN_WIDTH-1:0] TOP_RESET    = 16'sd0;
   localparam logic signed [WIN_WIDTH-1:0] RIGHT_RESET  = 16'sd32767;
   localparam logic signed [WIN_WIDTH-1:0] BOTTOM_RESET = 16'sd32767;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_LOAD,
      OP_EDGE_START,
      OP_EDGE_FINISH,
      OP_POP,
      OP_CLOSE_OUT
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [1:0] stage;
      logic       close;
   } cmd_type;

   typedef struct packed {
      logic       crossing;
      logic       div_done;
      logic [3:0] pend_empty;
      logic       rsp_busy;
   } status_type;

   typedef struct packed {
      logic signed [WIN_WIDTH-1:0] left;
      logic signed [WIN_WIDTH-1:0] top;
      logic signed [WIN_WIDTH-1:0] right;
      logic signed [WIN_WIDTH-1:0] bottom;
   } window_type;

endpackage

// File: sv/prc_div.sv
// multiply-divide unit: floor(a*b/c) one bit of b per cycle, then ao +/- quotient
// standalone, used by prc_datapath
module prc_div #(
   parameter int AW = 34
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [AW-1:0]        a,
   input  logic [AW-1:0]        b,
   input  logic [AW-1:0]        c,
   input  logic signed [AW-1:0] ao,
   input  logic                 neg,
   output logic                 done,
   output logic signed [AW-1:0] ro
);
   localparam int RW   = AW + 2;
   localparam int CNTW = $clog2(AW + 1);

   logic              busy_ff;
   logic [CNTW-1:0]   cnt_ff;
   logic [AW-1:0]     a_ff, b_ff, c_ff;
   logic [RW-1:0]     r_ff;
   logic [AW:0]       q_ff;
   logic signed [AW-1:0] ao_ff, ro_ff;
   logic              neg_ff, done_ff;

   logic [RW-1:0] r2_in, c1_in, c2_in, r_in;
   logic [1:0]    qinc_in;
   logic [AW:0]   q_in;
   logic signed [AW-1:0] qs_in, ro_in;

   always_comb begin
      r2_in = {r_ff[RW-2:0], 1'b0} + (b_ff[AW-1] ? RW'(a_ff) : '0);
      c1_in = RW'(c_ff);
      c2_in = {c1_in[RW-2:0], 1'b0};
      // remainder stays below c, so at most two subtractions per bit
      if (r2_in >= c2_in) begin
         r_in    = r2_in - c2_in;
         qinc_in = 2'd2;
      end else if (r2_in >= c1_in) begin
         r_in    = r2_in - c1_in;
         qinc_in = 2'd1;
      end else begin
         r_in    = r2_in;
         qinc_in = 2'd0;
      end
      q_in  = {q_ff[AW-1:0], 1'b0} + (AW + 1)'(qinc_in);
      qs_in = $signed({1'b0, q_ff[AW-2:0]});
      ro_in = neg_ff ? (ao_ff - qs_in) : (ao_ff + qs_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            a_ff    <= a;
            b_ff    <= b;
            c_ff    <= c;
            ao_ff   <= ao;
            neg_ff  <= neg;
            r_ff    <= '0;
            q_ff    <= '0;
            cnt_ff  <= CNTW'(AW);
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            if (cnt_ff != '0) begin
               r_ff   <= r_in;
               q_ff   <= q_in;
               b_ff   <= {b_ff[AW-2:0], 1'b0};
               cnt_ff <= cnt_ff - 1'b1;
            end else begin
               ro_ff   <= ro_in;
               done_ff <= 1'b1;
               busy_ff <= 1'b0;
            end
         end
      end
   end

   assign done = done_ff;
   assign ro   = ro_ff;

endmodule

// File: sv/prc_datapath.sv
// datapath: per-stage vertex registers, two-entry pending queues, held vertex, output register
// depends on prc_pkg and prc_div
module prc_datapath #(
   parameter int COORD_WIDTH = 24,
   parameter int FRAC_BITS   = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  prc_pkg::cmd_type              cmd,
   output prc_pkg::status_type           stat,
   input  prc_pkg::window_type           window,
   input  logic signed [COORD_WIDTH-1:0] req_vertex_x,
   input  logic signed [COORD_WIDTH-1:0] req_vertex_y,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic signed [COORD_WIDTH-1:0] rsp_out_x,
   output logic signed [COORD_WIDTH-1:0] rsp_out_y,
   output logic                          rsp_out_valid,
   output logic                          rsp_out_last
);
   localparam int CW = COORD_WIDTH;
   localparam int EW = (CW > prc_pkg::WIN_WIDTH + FRAC_BITS) ? CW
                       : prc_pkg::WIN_WIDTH + FRAC_BITS;
   localparam int AW = EW + 2;

   logic signed [CW-1:0] cur_x_ff [4], cur_y_ff [4];
   logic signed [CW-1:0] first_x_ff [4], first_y_ff [4];
   logic signed [CW-1:0] prev_x_ff [4], prev_y_ff [4];
   logic [3:0]           seen_ff;
   logic signed [CW-1:0] pend_x_ff [4][2], pend_y_ff [4][2];
   logic [1:0]           pend_wr_ff [4], pend_rd_ff [4];
   logic signed [CW-1:0] held_x_ff, held_y_ff, rsp_x_ff, rsp_y_ff;
   logic                 held_v_ff, rsp_vld_ff, rsp_last_ff, rsp_valid_ff;

   logic [1:0]                   s_in;
   logic signed [prc_pkg::WIN_WIDTH-1:0] win_in;
   logic signed [AW-1:0]         e_in, ac_in, ao_in, bc_in, bo_in, dn_in, dc_in, dd_in;
   logic signed [CW-1:0]         ax_in, ay_in, bx_in, by_in, px_in, py_in;
   logic [AW-1:0]                an_in, bn_in, cn_in;
   logic                         vert_in, inside_in, cross_in, neg_in, start_in, done_in;
   logic signed [AW-1:0]         ro_in;
   logic signed [CW-1:0]         ix_in, iy_in;

   always_comb begin
      s_in = cmd.stage;
      case (s_in)
         prc_pkg::REG_LEFT:  win_in = window.left;
         prc_pkg::REG_TOP:   win_in = window.top;
         prc_pkg::REG_RIGHT: win_in = window.right;
         default:            win_in = window.bottom;
      endcase
      e_in    = AW'(win_in) <<< FRAC_BITS;
      vert_in = !s_in[0];
      ax_in   = prev_x_ff[s_in];
      ay_in   = prev_y_ff[s_in];
      bx_in   = cmd.close ? first_x_ff[s_in] : cur_x_ff[s_in];
      by_in   = cmd.close ? first_y_ff[s_in] : cur_y_ff[s_in];
      ac_in   = vert_in ? AW'(ax_in) : AW'(ay_in);
      ao_in   = vert_in ? AW'(ay_in) : AW'(ax_in);
      bc_in   = vert_in ? AW'(bx_in) : AW'(by_in);
      bo_in   = vert_in ? AW'(by_in) : AW'(bx_in);
      // left and top keep c >= e, right and bottom keep c <= e
      inside_in = s_in[1] ? (ac_in <= e_in) : (ac_in >= e_in);
      cross_in  = ((ac_in < e_in) && (bc_in > e_in)) || ((bc_in < e_in) && (ac_in > e_in));
      dn_in   = e_in - ac_in;
      dc_in   = bc_in - ac_in;
      dd_in   = bo_in - ao_in;
      an_in   = dn_in[AW-1] ? AW'(-dn_in) : AW'(dn_in);
      cn_in   = dc_in[AW-1] ? AW'(-dc_in) : AW'(dc_in);
      bn_in   = dd_in[AW-1] ? AW'(-dd_in) : AW'(dd_in);
      neg_in  = dn_in[AW-1] ^ dd_in[AW-1] ^ dc_in[AW-1];
      start_in = (cmd.op == prc_pkg::OP_EDGE_START) && seen_ff[s_in] && cross_in;
      ix_in   = vert_in ? e_in[CW-1:0] : ro_in[CW-1:0];
      iy_in   = vert_in ? ro_in[CW-1:0] : e_in[CW-1:0];
      px_in   = pend_x_ff[s_in][pend_rd_ff[s_in][0]];
      py_in   = pend_y_ff[s_in][pend_rd_ff[s_in][0]];
   end

   prc_div #(.AW(AW)) u_div (
      .clock (clock),
      .reset (reset),
      .start (start_in),
      .a     (an_in),
      .b     (bn_in),
      .c     (cn_in),
      .ao    (ao_in),
      .neg   (neg_in),
      .done  (done_in),
      .ro    (ro_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff      <= '0;
         held_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 4; i++) begin
            pend_wr_ff[i] <= '0;
            pend_rd_ff[i] <= '0;
         end
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (cmd.op)
            prc_pkg::OP_LOAD: begin
               cur_x_ff[0] <= req_vertex_x;
               cur_y_ff[0] <= req_vertex_y;
            end
            prc_pkg::OP_EDGE_START: begin
               if (seen_ff[s_in]) begin
                  if (inside_in) begin
                     pend_x_ff[s_in][0] <= ax_in;
                     pend_y_ff[s_in][0] <= ay_in;
                     pend_wr_ff[s_in]   <= 2'd1;
                  end
                  if (cmd.close) begin
                     seen_ff[s_in] <= 1'b0;
                  end else begin
                     prev_x_ff[s_in] <= cur_x_ff[s_in];
                     prev_y_ff[s_in] <= cur_y_ff[s_in];
                  end
               end else if (!cmd.close) begin
                  first_x_ff[s_in] <= cur_x_ff[s_in];
                  first_y_ff[s_in] <= cur_y_ff[s_in];
                  prev_x_ff[s_in]  <= cur_x_ff[s_in];
                  prev_y_ff[s_in]  <= cur_y_ff[s_in];
                  seen_ff[s_in]    <= 1'b1;
               end
            end
            prc_pkg::OP_EDGE_FINISH: begin
               pend_x_ff[s_in][pend_wr_ff[s_in][0]] <= ix_in;
               pend_y_ff[s_in][pend_wr_ff[s_in][0]] <= iy_in;
               pend_wr_ff[s_in] <= pend_wr_ff[s_in] + 2'd1;
            end
            prc_pkg::OP_POP: begin
               if (pend_rd_ff[s_in] + 2'd1 == pend_wr_ff[s_in]) begin
                  pend_rd_ff[s_in] <= '0;
                  pend_wr_ff[s_in] <= '0;
               end else begin
                  pend_rd_ff[s_in] <= pend_rd_ff[s_in] + 2'd1;
               end
               if (s_in != prc_pkg::REG_BOTTOM) begin
                  cur_x_ff[s_in + 2'd1] <= px_in;
                  cur_y_ff[s_in + 2'd1] <= py_in;
               end else begin
                  // newest vertex waits in held so the last one can carry the close mark
                  if (held_v_ff) begin
                     rsp_x_ff     <= held_x_ff;
                     rsp_y_ff     <= held_y_ff;
                     rsp_vld_ff   <= 1'b1;
                     rsp_last_ff  <= 1'b0;
                     rsp_valid_ff <= 1'b1;
                  end
                  held_x_ff <= px_in;
                  held_y_ff <= py_in;
                  held_v_ff <= 1'b1;
               end
            end
            prc_pkg::OP_CLOSE_OUT: begin
               rsp_x_ff     <= held_v_ff ? held_x_ff : '0;
               rsp_y_ff     <= held_v_ff ? held_y_ff : '0;
               rsp_vld_ff   <= held_v_ff;
               rsp_last_ff  <= 1'b1;
               rsp_valid_ff <= 1'b1;
               held_v_ff    <= 1'b0;
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      stat.crossing = seen_ff[s_in] && cross_in;
      stat.div_done = done_in;
      stat.rsp_busy = rsp_valid_ff;
      for (int i = 0; i < 4; i++) begin
         stat.pend_empty[i] = (pend_rd_ff[i] == pend_wr_ff[i]);
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_x     = rsp_x_ff;
   assign rsp_out_y     = rsp_y_ff;
   assign rsp_out_valid = rsp_vld_ff;
   assign rsp_out_last  = rsp_last_ff;

endmodule

// File: sv/prc_ctrl.sv
// controller: walks each vertex depth first through the four clip stages, then the closing edges
// depends on prc_pkg
module prc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_closes_polygon,
   output logic                req_ready,
   input  prc_pkg::status_type stat,
   output prc_pkg::cmd_type    cmd
);
   typedef enum logic [2:0] {
      S_IDLE,
      S_EDGE,
      S_DIV,
      S_DRAIN,
      S_CLOSE,
      S_FINISH
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] stage_ff, stage_in, base_ff, base_in;
   logic       closing_ff, closing_in, phase_ff, phase_in;

   always_comb begin
      state_in   = state_ff;
      stage_in   = stage_ff;
      base_in    = base_ff;
      closing_in = closing_ff;
      phase_in   = phase_ff;
      cmd.op     = prc_pkg::OP_NONE;
      cmd.stage  = stage_ff;
      cmd.close  = 1'b0;
      req_ready  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op     = prc_pkg::OP_LOAD;
               state_in   = S_EDGE;
               stage_in   = 2'd0;
               base_in    = 2'd0;
               closing_in = req_closes_polygon;
               phase_in   = 1'b0;
            end
         end
         S_EDGE, S_CLOSE: begin
            cmd.op    = prc_pkg::OP_EDGE_START;
            cmd.close = (state_ff == S_CLOSE);
            state_in  = stat.crossing ? S_DIV : S_DRAIN;
         end
         S_DIV: begin
            if (stat.div_done) begin
               cmd.op   = prc_pkg::OP_EDGE_FINISH;
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (!stat.pend_empty[stage_ff]) begin
               if (stage_ff == 2'd3) begin
                  if (!stat.rsp_busy) begin
                     cmd.op = prc_pkg::OP_POP;
                  end
               end else begin
                  cmd.op   = prc_pkg::OP_POP;
                  stage_in = stage_ff + 2'd1;
                  state_in = S_EDGE;
               end
            end else if (stage_ff != base_ff) begin
               // deeper stages are empty, resume the one above
               stage_in = stage_ff - 2'd1;
            end else if (!closing_ff) begin
               state_in = S_IDLE;
            end else if (!phase_ff) begin
               phase_in = 1'b1;
               base_in  = 2'd0;
               stage_in = 2'd0;
               state_in = S_CLOSE;
            end else if (base_ff == 2'd3) begin
               state_in = S_FINISH;
            end else begin
               base_in  = base_ff + 2'd1;
               stage_in = base_ff + 2'd1;
               state_in = S_CLOSE;
            end
         end
         S_FINISH: begin
            if (!stat.rsp_busy) begin
               cmd.op   = prc_pkg::OP_CLOSE_OUT;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         stage_ff   <= '0;
         base_ff    <= '0;
         closing_ff <= 1'b0;
         phase_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         stage_ff   <= stage_in;
         base_ff    <= base_in;
         closing_ff <= closing_in;
         phase_ff   <= phase_in;
      end
   end

endmodule

// File: sv/polygon_rect_clipper_core.sv
// top level of the polygon rectangle clipper: window registers, controller and datapath
// depends on prc_pkg, prc_ctrl, prc_datapath
//
//  channel  direction  handshake                      payload
//  req      in         req_valid / req_ready          vertex_x, vertex_y, closes_polygon
//  rsp      out        rsp_valid / rsp_ready          out_x, out_y, out_valid, out_last
//  csr      in/out     psel, penable, pwrite, pready  paddr, pwdata, prdata (window edges)
//
// a vertex is loaded, then each stage takes its edge, passes each word on and steps back up
// an edge that strictly crosses a window line also passes through the shared bit-serial divider
// a closing vertex then walks the four closing edges and finally puts out the last word
// reset is synchronous, active high, and restores the window to 0, 0, 32767, 32767
// a pending rsp word holds the walk whenever the last stage passes a word on or closes
module polygon_rect_clipper_core #(
   parameter int COORD_WIDTH = 24,
   parameter int FRAC_BITS   = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [COORD_WIDTH-1:0] req_vertex_x,
   input  logic signed [COORD_WIDTH-1:0] req_vertex_y,
   input  logic                          req_closes_polygon,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [COORD_WIDTH-1:0] rsp_out_x,
   output logic signed [COORD_WIDTH-1:0] rsp_out_y,
   output logic                          rsp_out_valid,
   output logic                          rsp_out_last,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [3:0]                    paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);
   prc_pkg::window_type   window_ff;
   prc_pkg::cmd_type      cmd;
   prc_pkg::status_type   stat;
   logic                  wr_in;
   logic signed [prc_pkg::WIN_WIDTH-1:0] rd_in;

   assign pready = 1'b1;
   assign wr_in  = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff.left   <= prc_pkg::LEFT_RESET;
         window_ff.top    <= prc_pkg::TOP_RESET;
         window_ff.right  <= prc_pkg::RIGHT_RESET;
         window_ff.bottom <= prc_pkg::BOTTOM_RESET;
      end else if (wr_in) begin
         unique case (paddr[3:2])
            prc_pkg::REG_LEFT:   window_ff.left   <= pwdata[15:0];
            prc_pkg::REG_TOP:    window_ff.top    <= pwdata[15:0];
            prc_pkg::REG_RIGHT:  window_ff.right  <= pwdata[15:0];
            prc_pkg::REG_BOTTOM: window_ff.bottom <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         prc_pkg::REG_LEFT:   rd_in = window_ff.left;
         prc_pkg::REG_TOP:    rd_in = window_ff.top;
         prc_pkg::REG_RIGHT:  rd_in = window_ff.right;
         default:             rd_in = window_ff.bottom;
      endcase
      prdata = 32'(rd_in);
   end

   prc_ctrl u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_closes_polygon (req_closes_polygon),
      .req_ready          (req_ready),
      .stat               (stat),
      .cmd                (cmd)
   );

   prc_datapath #(
      .COORD_WIDTH (COORD_WIDTH),
      .FRAC_BITS   (FRAC_BITS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .window        (window_ff),
      .req_vertex_x  (req_vertex_x),
      .req_vertex_y  (req_vertex_y),
      .rsp_ready     (rsp_ready),
      .rsp_valid     (rsp_valid),
      .rsp_out_x     (rsp_out_x),
      .rsp_out_y     (rsp_out_y),
      .rsp_out_valid (rsp_out_valid),
      .rsp_out_last  (rsp_out_last)
   );

`ifndef SYNTHESIS
   a_load_on_accept: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == prc_pkg::OP_LOAD) |-> (req_valid && req_ready))
      else $error("vertex loaded without an accepted word");

   a_no_rsp_overwrite: assert property (@(posedge clock) disable iff (reset)
      ((cmd.op == prc_pkg::OP_CLOSE_OUT) ||
       ((cmd.op == prc_pkg::OP_POP) && (cmd.stage == prc_pkg::REG_BOTTOM)))
      |-> !stat.rsp_busy)
      else $error("output register written while a word is pending");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == prc_pkg::OP_POP) |-> !stat.pend_empty[cmd.stage])
      else $error("pop from an empty stage queue");
`endif

endmodule

// File: bench/prc_checker.sv
`timescale 1ns / 1ps
// predictor and scoreboard for the polygon rectangle clipper
// watches the req, rsp and csr ports of polygon_rect_clipper_core; uses prc_pkg
module prc_checker #(
   parameter int COORD_WIDTH = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic signed [COORD_WIDTH-1:0] req_vertex_x,
   input  logic signed [COORD_WIDTH-1:0] req_vertex_y,
   input  logic                          req_closes_polygon,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [COORD_WIDTH-1:0]        rsp_out_x,
   input  logic [COORD_WIDTH-1:0]        rsp_out_y,
   input  logic                          rsp_out_valid,
   input  logic                          rsp_out_last,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic                          pready,
   input  logic [3:0]                    paddr,
   input  logic [31:0]                   pwdata,
   output int                            mismatch_count,
   output int                            words_pending
);
   typedef struct {
      logic [COORD_WIDTH-1:0] x;
      logic [COORD_WIDTH-1:0] y;
      logic                   v;
      logic                   l;
   } clip_word_type;

   clip_word_type clipped_words[$];

   longint win_edge[4];
   longint first_x[4], first_y[4], prev_x[4], prev_y[4];
   bit     seen[4];
   bit     held_valid;
   longint held_x, held_y;
   longint edge_out_x[$], edge_out_y[$];

   assign words_pending = clipped_words.size();

   // one window edge, appends survivors and crossings to edge_out
   task automatic clip_edge(input int s, input longint ax, input longint ay,
                            input longint bx, input longint by);
      bit     vert;
      longint e, ac, ao, bc, bo, dn, dc, dd, ro, q;
      bit     neg, a_in;
      vert = (s == prc_pkg::REG_LEFT) || (s == prc_pkg::REG_RIGHT);
      e    = win_edge[s] * (longint'(1) << 8);
      ac = vert ? ax : ay;  ao = vert ? ay : ax;
      bc = vert ? bx : by;  bo = vert ? by : bx;
      a_in = (s < 2) ? (ac >= e) : (ac <= e);
      if (a_in) begin
         edge_out_x = {edge_out_x, ax};
         edge_out_y = {edge_out_y, ay};
      end
      if ((ac < e && bc > e) || (bc < e && ac > e)) begin
         dn = e - ac;  dc = bc - ac;  dd = bo - ao;
         if (dd == 0) begin
            ro = ao;
         end else begin
            q   = ((dn < 0 ? -dn : dn) * (dd < 0 ? -dd : dd)) / (dc < 0 ? -dc : dc);
            neg = ((dn < 0) != (dd < 0)) != (dc < 0);
            ro  = neg ? ao - q : ao + q;
         end
         edge_out_x = {edge_out_x, (vert ? e : ro)};
         edge_out_y = {edge_out_y, (vert ? ro : e)};
      end
   endtask

   task automatic predict_vertex(input longint vx, input longint vy, input bit closing);
      longint        cur_x[$], cur_y[$], lx[$], ly[$];
      clip_word_type w;
      int            total;
      cur_x = {vx};
      cur_y = {vy};
      for (int s = 0; s < 4; s++) begin
         edge_out_x.delete();
         edge_out_y.delete();
         foreach (cur_x[i]) begin
            if (!seen[s]) begin
               first_x[s] = cur_x[i];
               first_y[s] = cur_y[i];
               seen[s] = 1;
            end else begin
               clip_edge(s, prev_x[s], prev_y[s], cur_x[i], cur_y[i]);
            end
            prev_x[s] = cur_x[i];
            prev_y[s] = cur_y[i];
         end
         if (closing && seen[s]) begin
            clip_edge(s, prev_x[s], prev_y[s], first_x[s], first_y[s]);
            seen[s] = 0;
         end
         cur_x = edge_out_x;
         cur_y = edge_out_y;
      end
      if (held_valid) begin
         lx = {lx, held_x};
         ly = {ly, held_y};
      end
      foreach (cur_x[i]) begin
         lx = {lx, cur_x[i]};
         ly = {ly, cur_y[i]};
      end
      if (closing) begin
         held_valid = 0;
         if (lx.size() == 0) begin
            w.x = '0;  w.y = '0;  w.v = 0;  w.l = 1;
            clipped_words = {clipped_words, w};
            return;
         end
         total = lx.size();
      end else begin
         if (lx.size() == 0) return;
         held_valid = 1;
         held_x = lx[lx.size()-1];
         held_y = ly[ly.size()-1];
         total = lx.size() - 1;
      end
      if (total > 46) total = 46;
      for (int k = 0; k < total; k++) begin
         w.x = lx[k][COORD_WIDTH-1:0];
         w.y = ly[k][COORD_WIDTH-1:0];
         w.v = 1;
         w.l = closing && (k == total - 1);
         clipped_words = {clipped_words, w};
      end
   endtask

   always @(posedge clock) begin
      clip_word_type w;
      if (reset) begin
         win_edge[prc_pkg::REG_LEFT]   = prc_pkg::LEFT_RESET;
         win_edge[prc_pkg::REG_TOP]    = prc_pkg::TOP_RESET;
         win_edge[prc_pkg::REG_RIGHT]  = prc_pkg::RIGHT_RESET;
         win_edge[prc_pkg::REG_BOTTOM] = prc_pkg::BOTTOM_RESET;
         for (int s = 0; s < 4; s++) begin
            first_x[s] = 0;  first_y[s] = 0;  prev_x[s] = 0;  prev_y[s] = 0;
            seen[s] = 0;
         end
         held_valid = 0;  held_x = 0;  held_y = 0;
         clipped_words.delete();
         mismatch_count = 0;
      end else begin
         if (psel && penable && pwrite && pready)
            win_edge[paddr[3:2]] = longint'($signed(pwdata[15:0]));
         if (req_valid && req_ready)
            predict_vertex(longint'(req_vertex_x), longint'(req_vertex_y),
                           req_closes_polygon);
         if (rsp_valid && rsp_ready) begin
            if (clipped_words.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected word x=%h y=%h v=%b l=%b", rsp_out_x, rsp_out_y,
                           rsp_out_valid, rsp_out_last);
            end else begin
               w = clipped_words.pop_front();
               if (w.x !== rsp_out_x || w.y !== rsp_out_y || w.v !== rsp_out_valid
                   || w.l !== rsp_out_last) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("mismatch exp x=%h y=%h v=%b l=%b got x=%h y=%h v=%b l=%b",
                              w.x, w.y, w.v, w.l, rsp_out_x, rsp_out_y, rsp_out_valid,
                              rsp_out_last);
               end
            end
         end
      end
   end
endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// stimulus and verdict for polygon_rect_clipper_core
// instantiates the block and prc_checker; uses prc_pkg
module tb_top;
   localparam int CW = 24;
   localparam longint CMAX = 8388607;
   localparam longint CMIN = -8388608;

   logic                 clock = 0;
   logic                 reset = 1;
   logic                 req_valid = 0;
   logic                 req_ready;
   logic signed [CW-1:0] req_vertex_x = '0;
   logic signed [CW-1:0] req_vertex_y = '0;
   logic                 req_closes_polygon = 0;
   logic                 rsp_valid;
   logic                 rsp_ready = 0;
   logic signed [CW-1:0] rsp_out_x, rsp_out_y;
   logic                 rsp_out_valid, rsp_out_last;
   logic                 psel = 0, penable = 0, pwrite = 0;
   logic [3:0]           paddr = '0;
   logic [31:0]          pwdata = '0;
   logic [31:0]          prdata;
   logic                 pready;

   int     mismatch_count, words_pending;
   bit     no_idle = 0;
   bit     hold_go = 0, hold_done = 0;
   longint win_l = 0, win_t = 0, win_r = 32767, win_b = 32767;

   always #10 clock = ~clock;

   polygon_rect_clipper_core u_top (.*);

   prc_checker #(.COORD_WIDTH(CW)) u_checker (
      .clock, .reset, .req_valid, .req_ready, .req_vertex_x, .req_vertex_y,
      .req_closes_polygon, .rsp_valid, .rsp_ready, .rsp_out_x, .rsp_out_y,
      .rsp_out_valid, .rsp_out_last, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
      .mismatch_count, .words_pending
   );

   task automatic csr_write(input logic [1:0] idx, input longint value);
      psel <= 1;  penable <= 0;  pwrite <= 1;
      paddr <= {idx, 2'b00};
      pwdata <= 32'(value);
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      psel <= 0;  penable <= 0;  pwrite <= 0;
   endtask

   task automatic set_window(input longint l, input longint t, input longint r,
                             input longint b);
      win_l = l;  win_t = t;  win_r = r;  win_b = b;
      csr_write(prc_pkg::REG_LEFT, l);
      csr_write(prc_pkg::REG_TOP, t);
      csr_write(prc_pkg::REG_RIGHT, r);
      csr_write(prc_pkg::REG_BOTTOM, b);
   endtask

   task automatic send_vertex(input longint x, input longint y, input bit closing);
      if (!no_idle && $urandom_range(0, 3) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid <= 1;
      req_vertex_x <= CW'(x);
      req_vertex_y <= CW'(y);
      req_closes_polygon <= closing;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // wait for every expected word, then let a non-producing vertex drain
   task automatic drain;
      req_valid <= 0;
      @(posedge clock);
      while (words_pending != 0) @(posedge clock);
      repeat (1000) @(posedge clock);
   endtask

   function automatic longint pick(input longint lo, input longint hi);
      longint a, b;
      a = (lo < hi) ? lo : hi;
      b = (lo < hi) ? hi : lo;
      a = a - 3000;  b = b + 3000;
      if (a < CMIN) a = CMIN;
      if (b > CMAX) b = CMAX;
      return a + longint'($urandom_range(0, 32'(b - a)));
   endfunction

   function automatic longint any_coord();
      return longint'($signed(24'($urandom)));
   endfunction

   task automatic random_polygons(input int n_items);
      int sent, nv;
      sent = 0;
      while (sent < n_items) begin
         nv = $urandom_range(1, 8);
         for (int i = 0; i < nv; i++) begin
            if ($urandom_range(0, 4) == 0)
               send_vertex(any_coord(), any_coord(), i == nv - 1);
            else
               send_vertex(pick(win_l * 256, win_r * 256), pick(win_t * 256, win_b * 256),
                           i == nv - 1);
            sent++;
         end
      end
   endtask

   // receiver side idling
   initial begin
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_go && !hold_done) begin
            rsp_ready <= 0;
            repeat (3000) @(posedge clock);
            hold_done = 1;
         end else if (no_idle || $urandom_range(0, 4) != 0) begin
            rsp_ready <= 1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end else begin
            rsp_ready <= 0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
   end

   initial begin
      #20ms;
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // reset window: extremes, boundary, parallel edges, empty and single vertex
      send_vertex(100, 200, 1);
      send_vertex(-100, 200, 1);
      send_vertex(0, 0, 1);
      send_vertex(CMAX, CMAX, 1);
      send_vertex(CMIN, CMIN, 1);
      send_vertex(CMIN, CMAX, 0);
      send_vertex(CMAX, CMIN, 1);
      send_vertex(-512, 300, 0);
      send_vertex(512, 300, 0);
      send_vertex(512, -700, 0);
      send_vertex(-512, -700, 1);
      send_vertex(-1000, 5000, 0);
      send_vertex(3000, -1000, 0);
      send_vertex(8000, 9000, 1);
      send_vertex(-5, -5, 0);
      send_vertex(-5, -9, 1);
      drain();

      set_window(10, 20, 100, 90);
      hold_go = 1;
      random_polygons(44);
      drain();
      set_window(-32768, -32768, 32767, 32767);
      send_vertex(CMIN, CMIN, 0);
      send_vertex(CMAX, CMIN, 0);
      send_vertex(CMAX, CMAX, 1);
      random_polygons(20);
      drain();
      set_window(50, 50, -50, -50);
      random_polygons(44);
      drain();
      set_window(0, 0, 0, 0);
      random_polygons(44);
      drain();
      set_window(-200, -100, 300, 150);
      no_idle = 1;
      random_polygons(44);
      drain();

      if (mismatch_count == 0 && words_pending == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule

// File: sim.f
sv/prc_pkg.sv
sv/prc_div.sv
sv/prc_datapath.sv
sv/prc_ctrl.sv
sv/polygon_rect_clipper_core.sv
bench/prc_checker.sv
bench/tb_top.sv
